[rtl/core/lzexe_pkg.sv]
// Package for the LZ decompressor: parse phases, command word between
// the byte parser and the copy engine. No dependencies.
package lzexe_pkg;

  typedef enum logic [8:0] {
    PH_TOKEN     = 9'b000000001,
    PH_KIND      = 9'b000000010,
    PH_SHORT_HI  = 9'b000000100,
    PH_SHORT_LO  = 9'b000001000,
    PH_SHORT_OFF = 9'b000010000,
    PH_LITERAL   = 9'b000100000,
    PH_LONG_OFF  = 9'b001000000,
    PH_LONG_LEN  = 9'b010000000,
    PH_LONG_EXT  = 9'b100000000
  } phase_e;

  typedef enum logic [1:0] {
    CMD_LIT   = 2'd0,
    CMD_MATCH = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_kind_e;

  // One command per accepted input byte; CMD_NONE still closes the byte.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  lit;
    logic [15:0] distance;
    logic [8:0]  len;
  } cmd_t;

  localparam int unsigned MaxResults = 32;

endpackage

[rtl/core/lzexe_parser.sv]
// Front end: control word handling and token classification, one byte
// per cycle while the command output is ready. Depends on lzexe_pkg.
module lzexe_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [7:0]     in_byte_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output lzexe_pkg::cmd_t cmd_o
);
  import lzexe_pkg::*;

  logic [15:0] word_q, word_d;
  logic [4:0]  left_q, left_d;
  logic        low_q, low_d;
  phase_e      ph_q, ph_d;
  logic [7:0]  off_lo_q, off_lo_d;
  logic [12:0] long_off_q, long_off_d;
  logic [8:0]  len_q, len_d;
  logic        fin_q, fin_d;
  cmd_t        cmd;
  logic        take;

  // A finished stream swallows bytes without commands.
  assign ready_o = fin_q || cmd_ready_i;
  assign take    = valid_i && ready_o && !fin_q;
  assign cmd_valid_o = valid_i && !fin_q;
  assign cmd_o   = cmd;

  // Decode one byte, then consume up to four control bits.
  always_comb begin
    logic [15:0] w;
    logic [4:0]  l;
    phase_e      p;
    logic [8:0]  n;
    logic        ended;
    w = word_q; l = left_q; p = ph_q; n = len_q; ended = 1'b0;
    low_d = low_q; off_lo_d = off_lo_q; long_off_d = long_off_q; fin_d = fin_q;
    cmd = '{kind: CMD_NONE, lit: in_byte_i, distance: 16'd0, len: 9'd0};
    if (left_q == 5'd0) begin
      if (!low_q) begin
        w = {8'd0, in_byte_i}; low_d = 1'b1;
      end else begin
        w = {in_byte_i, word_q[7:0]}; l = 5'd16; low_d = 1'b0;
      end
    end else begin
      case (ph_q)
        PH_LITERAL: begin
          cmd.kind = CMD_LIT; p = PH_TOKEN;
        end
        PH_SHORT_OFF: begin
          cmd.kind = CMD_MATCH;
          cmd.distance = 16'h0100 - {8'd0, in_byte_i};
          cmd.len = n; p = PH_TOKEN;
        end
        PH_LONG_OFF: begin
          off_lo_d = in_byte_i; p = PH_LONG_LEN;
        end
        PH_LONG_LEN: begin
          long_off_d = {in_byte_i[7:3], off_lo_q};
          n = {6'd0, in_byte_i[2:0]} + 9'd2;
          if (in_byte_i[2:0] == 3'd0) begin
            p = PH_LONG_EXT;
          end else begin
            cmd.kind = CMD_MATCH;
            cmd.distance = 16'h2000 - {3'd0, in_byte_i[7:3], off_lo_q};
            cmd.len = n; p = PH_TOKEN;
          end
        end
        PH_LONG_EXT: begin
          if (in_byte_i == 8'd0) begin
            cmd.kind = CMD_END; fin_d = 1'b1; ended = 1'b1;
          end else begin
            if (in_byte_i != 8'd1) begin
              cmd.kind = CMD_MATCH;
              cmd.distance = 16'h2000 - {3'd0, long_off_q};
              cmd.len = {1'b0, in_byte_i} + 9'd1;
            end
            p = PH_TOKEN;
          end
        end
        default: ;
      endcase
    end
    // At most four bit-consuming phases occur before a byte phase.
    for (int i = 0; i < 4; i++) begin
      if (!ended && l != 5'd0) begin
        case (p)
          PH_TOKEN: begin
            p = w[0] ? PH_LITERAL : PH_KIND; w = w >> 1; l = l - 5'd1;
          end
          PH_KIND: begin
            p = w[0] ? PH_LONG_OFF : PH_SHORT_HI; w = w >> 1; l = l - 5'd1;
          end
          PH_SHORT_HI: begin
            n = {7'd0, w[0], 1'b0}; p = PH_SHORT_LO; w = w >> 1; l = l - 5'd1;
          end
          PH_SHORT_LO: begin
            n = (n | {8'd0, w[0]}) + 9'd2; p = PH_SHORT_OFF;
            w = w >> 1; l = l - 5'd1;
          end
          default: ;
        endcase
      end
    end
    word_d = w; left_d = l; ph_d = p; len_d = n;
  end

  // Advance parse state on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0; left_q <= '0; low_q <= 1'b0; ph_q <= PH_TOKEN;
      off_lo_q <= '0; long_off_q <= '0; len_q <= '0; fin_q <= 1'b0;
    end else if (take) begin
      word_q <= word_d; left_q <= left_d; low_q <= low_d; ph_q <= ph_d;
      off_lo_q <= off_lo_d; long_off_q <= long_off_d; len_q <= len_d;
      fin_q <= fin_d;
    end
  end
endmodule

[rtl/core/lzexe_cmd_fifo.sv]
// Two-entry command queue between parser and copy engine.
// Depends on lzexe_pkg.
module lzexe_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  lzexe_pkg::cmd_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output lzexe_pkg::cmd_t rd_data_o
);
  import lzexe_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // Store words without reset.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

[rtl/core/lzexe_copy.sv]
// Back end: history memory, byte copy loop and result packing.
// Depends on lzexe_pkg.
module lzexe_copy #(
  parameter int unsigned WindowSize     = 8192,
  parameter int unsigned BytesPerResult = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  lzexe_pkg::cmd_t cmd_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [63:0]     out_bytes_o,
  output logic [3:0]      out_count_o,
  output logic            run_last_o,
  output logic            stream_end_o,
  output logic            bad_reference_o
);
  import lzexe_pkg::*;

  localparam int unsigned AW = $clog2(WindowSize);
  localparam int unsigned PW = $clog2(WindowSize + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_COPY = 3'b010,
    S_WAIT = 3'b100
  } st_e;

  logic [7:0]    hist_q [WindowSize];
  st_e           st_q;
  logic [AW-1:0] wpos_q;
  logic [PW-1:0] prod_q;
  logic [8:0]    rem_q;
  logic [16:0]   dist_q;
  logic [63:0]   acc_q;
  logic [3:0]    n_q;
  logic          bad_q;
  logic [5:0]    res_q;
  logic          rd_pend_q, rd_bad_q;
  logic [7:0]    rd_q;
  logic          ov_q;
  logic [63:0]   ob_q;
  logic [3:0]    oc_q;
  logic          ol_q, oe_q, obad_q;

  logic          out_free;
  logic          emit;
  logic [7:0]    eb;
  logic          ebad;
  logic          last_emit;
  logic [63:0]   acc_n;
  logic [3:0]    cnt_n;
  logic          full;
  logic          src_ok;
  logic [AW-1:0] src;
  logic          end_load;
  logic          res_load;

  assign valid_o = ov_q;
  assign out_bytes_o = ob_q;
  assign out_count_o = oc_q;
  assign run_last_o = ol_q;
  assign stream_end_o = oe_q;
  assign bad_reference_o = obad_q;

  // Take a command only when idle and the output register can hold a result.
  assign out_free = !ov_q || ready_i;
  assign cmd_ready_o = (st_q == S_IDLE) && !rd_pend_q && out_free;
  assign end_load = cmd_valid_i && cmd_ready_o && (cmd_i.kind == CMD_END);

  assign src_ok = 32'(dist_q) <= 32'(prod_q);
  assign src = wpos_q - dist_q[AW-1:0];

  // Select the byte being emitted this cycle.
  always_comb begin
    emit = 1'b0; eb = 8'd0; ebad = 1'b0; last_emit = 1'b0;
    if (cmd_valid_i && cmd_ready_o && cmd_i.kind == CMD_LIT) begin
      emit = 1'b1; eb = cmd_i.lit; last_emit = 1'b1;
    end else if (rd_pend_q && out_free) begin
      emit = 1'b1; eb = rd_bad_q ? 8'd0 : rd_q; ebad = rd_bad_q;
      last_emit = (rem_q == 9'd0);
    end
    acc_n = acc_q | ({56'd0, eb} << {n_q, 3'b000});
    cnt_n = n_q + 4'd1;
    full  = cnt_n == 4'(BytesPerResult);
    res_load = emit && (full || last_emit) && (res_q < 6'(MaxResults));
  end

  // Write emitted bytes; read the source byte when a copy step starts.
  always_ff @(posedge clk_i) begin
    if (emit) hist_q[wpos_q] <= eb;
    if (st_q == S_COPY && !rd_pend_q) rd_q <= hist_q[src];
  end

  // Load a finished result or the end mark; drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; ob_q <= '0; oc_q <= '0; ol_q <= 1'b0; oe_q <= 1'b0;
      obad_q <= 1'b0;
    end else if (res_load) begin
      ov_q <= 1'b1; ob_q <= acc_n; oc_q <= cnt_n;
      ol_q <= last_emit || (res_q == 6'(MaxResults - 1));
      oe_q <= 1'b0; obad_q <= bad_q || ebad;
    end else if (end_load) begin
      ov_q <= 1'b1; ob_q <= '0; oc_q <= '0; ol_q <= 1'b1;
      oe_q <= 1'b1; obad_q <= 1'b0;
    end else if (ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Run the copy sequencer and pack results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; wpos_q <= '0; prod_q <= '0; rem_q <= '0; dist_q <= '0;
      acc_q <= '0; n_q <= '0; bad_q <= 1'b0; res_q <= '0; rd_pend_q <= 1'b0;
      rd_bad_q <= 1'b0;
    end else begin
      if (emit) begin
        wpos_q <= wpos_q + AW'(1);
        if (prod_q != PW'(WindowSize)) prod_q <= prod_q + PW'(1);
        rd_pend_q <= 1'b0;
        if (full || last_emit) begin
          if (last_emit) res_q <= 6'd0;
          else if (res_q != 6'(MaxResults)) res_q <= res_q + 6'd1;
          acc_q <= '0; n_q <= '0; bad_q <= 1'b0;
        end else begin
          acc_q <= acc_n; n_q <= cnt_n; bad_q <= bad_q || ebad;
        end
        if (last_emit) st_q <= S_IDLE;
      end
      case (st_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_ready_o && cmd_i.kind == CMD_MATCH) begin
            st_q <= S_COPY; rem_q <= cmd_i.len; dist_q <= {1'b0, cmd_i.distance};
          end
        end
        S_COPY: begin
          if (!rd_pend_q && !emit) begin
            rd_pend_q <= 1'b1; rd_bad_q <= !src_ok; rem_q <= rem_q - 9'd1;
            st_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (emit && !last_emit) st_q <= S_COPY;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/lzexe_style_lz_decompressor_unit.sv]
// LZ decompressor top level: parser, command queue and copy engine.
// Depends on lzexe_pkg, lzexe_parser, lzexe_cmd_fifo, lzexe_copy.
//
// Takes one compressed byte per cycle while the command queue has room;
// control word bytes, offset bytes and segment changes cost nothing in the
// copy engine, which handles a literal or the end mark in the cycle it takes
// it. A match is first loaded, then for each byte a registered read of the
// history memory is followed by its write. The queue lets the parser run up
// to two commands ahead; a stalled result receiver holds the engine, then
// the queue, then the input. Results carry up to BytesPerResult bytes; the
// final one of each input byte has run_last_o set.
module lzexe_style_lz_decompressor_unit #(
  parameter int unsigned WindowSize     = 8192,
  parameter int unsigned BytesPerResult = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  out_count_o,
  output logic        run_last_o,
  output logic        stream_end_o,
  output logic        bad_reference_o
);
  import lzexe_pkg::*;

  logic p_valid, p_ready, q_valid, q_ready;
  cmd_t p_cmd, q_cmd;
  logic c_ready;
  logic c_valid;

  lzexe_parser u_parser (
    .clk_i, .rst_ni, .valid_i, .ready_o, .in_byte_i,
    .cmd_valid_o(p_valid), .cmd_ready_i(p_ready), .cmd_o(p_cmd)
  );

  lzexe_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(p_valid), .wr_ready_o(p_ready), .wr_data_i(p_cmd),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_cmd)
  );

  // Drop empty commands here; the rest leave the queue when the engine takes them.
  assign q_ready = (q_cmd.kind == CMD_NONE) ? 1'b1 : c_ready;
  assign c_valid = q_valid && (q_cmd.kind != CMD_NONE);

  lzexe_copy #(.WindowSize(WindowSize), .BytesPerResult(BytesPerResult)) u_copy (
    .clk_i, .rst_ni, .cmd_valid_i(c_valid), .cmd_ready_o(c_ready), .cmd_i(q_cmd),
    .valid_o, .ready_i, .out_bytes_o, .out_count_o, .run_last_o,
    .stream_end_o, .bad_reference_o
  );

  // Output count never exceeds a full result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_count_o <= 4'(BytesPerResult))
    else $error("result count too large");
  // End mark carries no bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stream_end_o |-> out_count_o == 4'd0 && run_last_o)
    else $error("end mark malformed");
  // Stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(out_bytes_o))
    else $error("result dropped");
endmodule
